FILE: hw/rtl/tbc_pkg.sv
// Shared widths, pipeline word types and constants for the barycentric weight block.
// Used by every module of the block; no dependencies.
package tbc_pkg;

  localparam int COORD_W   = 16;               // input coordinate width
  localparam int DIFF_W    = COORD_W + 1;      // edge / offset component
  localparam int PROD_W    = 2 * DIFF_W;       // component product
  localparam int DOT_W     = PROD_W + 1;       // sum of three products
  localparam int SPLIT     = 18;               // low slice of the Gram multiplier operand
  localparam int GPROD_W   = 2 * DOT_W;        // product of two dot products
  localparam int NUM_W     = GPROD_W + 2;      // den, nv, nw, nu
  localparam int FRAC_BITS = 12;               // weight fraction bits
  localparam int WEIGHT_W  = 16;               // weight field width
  localparam int R_W       = NUM_W + WEIGHT_W; // divider remainder / shifted divisor
  localparam int N_CELLS   = WEIGHT_W;         // one quotient bit per cell
  localparam int N_LANES   = 3;                // u, v, w

  localparam logic [WEIGHT_W-1:0] W_POS_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] W_NEG_MAX = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef struct packed {
    logic [R_W-1:0]      rem;   // running remainder
    logic [R_W-1:0]      dsh;   // divisor aligned to the current quotient bit
    logic [WEIGHT_W-1:0] q;
    logic                neg;
    logic                big;   // quotient known to exceed the field, or word degenerate
  } lane_t;

  typedef struct packed {
    lane_t [N_LANES-1:0] lane;
    logic                degen;
  } div_word_t;

endpackage

FILE: hw/rtl/tbc_if.sv
// Channel interfaces: query word in, weight word out.
// Depends on tbc_pkg.
interface tbc_in_if;
  logic valid;
  logic ready;
  logic signed [tbc_pkg::COORD_W-1:0] vertex_a_x, vertex_a_y, vertex_a_z;
  logic signed [tbc_pkg::COORD_W-1:0] vertex_b_x, vertex_b_y, vertex_b_z;
  logic signed [tbc_pkg::COORD_W-1:0] vertex_c_x, vertex_c_y, vertex_c_z;
  logic signed [tbc_pkg::COORD_W-1:0] query_x, query_y, query_z;

  modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z,
                  vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                  query_x, query_y, query_z, input ready);
  modport sink   (input valid, vertex_a_x, vertex_a_y, vertex_a_z,
                  vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                  query_x, query_y, query_z, output ready);
endinterface

interface tbc_out_if;
  logic valid;
  logic ready;
  logic signed [tbc_pkg::WEIGHT_W-1:0] weight_u, weight_v, weight_w;
  logic degenerate;

  modport source (output valid, weight_u, weight_v, weight_w, degenerate, input ready);
  modport sink   (input valid, weight_u, weight_v, weight_w, degenerate, output ready);
endinterface

FILE: hw/rtl/tbc_front.sv
// Front pipeline: differences, dot products, Gram determinant and numerators,
// magnitudes and divider setup. Eight stages with bubble-collapsing handshake.
// Depends on tbc_pkg, tbc_if.
module tbc_front (
  input  logic                clk,
  input  logic                rst,
  tbc_in_if.sink              item,
  output tbc_pkg::div_word_t  word,
  output logic                word_valid,
  input  logic                word_ready
);

  logic [8:1] v;
  logic [8:1] en;

  always_comb begin
    en[8] = !v[8] || word_ready;
    for (int s = 7; s >= 1; s--) en[s] = !v[s] || en[s+1];
  end

  assign item.ready = en[1];
  assign word_valid = v[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= item.valid;
      for (int s = 2; s <= 8; s++) if (en[s]) v[s] <= v[s-1];
    end
  end

  // stage 1: e1 = B - A, e2 = C - A, qd = P - A
  logic signed [tbc_pkg::COORD_W-1:0] ca [3], cb [3], cc [3], cp [3];
  logic signed [tbc_pkg::DIFF_W-1:0]  e1 [3], e2 [3], qd [3];

  always_comb begin
    ca = '{item.vertex_a_x, item.vertex_a_y, item.vertex_a_z};
    cb = '{item.vertex_b_x, item.vertex_b_y, item.vertex_b_z};
    cc = '{item.vertex_c_x, item.vertex_c_y, item.vertex_c_z};
    cp = '{item.query_x, item.query_y, item.query_z};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= tbc_pkg::DIFF_W'(cb[k]) - tbc_pkg::DIFF_W'(ca[k]);
        e2[k] <= tbc_pkg::DIFF_W'(cc[k]) - tbc_pkg::DIFF_W'(ca[k]);
        qd[k] <= tbc_pkg::DIFF_W'(cp[k]) - tbc_pkg::DIFF_W'(ca[k]);
      end
    end
  end

  // stage 2: component products; order d11, d12, d22, d31, d32
  logic signed [tbc_pkg::PROD_W-1:0] pr [5][3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        pr[0][k] <= e1[k] * e1[k];
        pr[1][k] <= e1[k] * e2[k];
        pr[2][k] <= e2[k] * e2[k];
        pr[3][k] <= qd[k] * e1[k];
        pr[4][k] <= qd[k] * e2[k];
      end
    end
  end

  // stage 3: dot products
  logic signed [tbc_pkg::DOT_W-1:0] dot [5];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 5; i++) begin
        dot[i] <= tbc_pkg::DOT_W'(pr[i][0]) + tbc_pkg::DOT_W'(pr[i][1])
                + tbc_pkg::DOT_W'(pr[i][2]);
      end
    end
  end

  // stage 4: Gram products split on the second operand
  // pairs: d11*d22, d12*d12, d22*d31, d12*d32, d11*d32, d12*d31
  logic signed [tbc_pkg::DOT_W-1:0]             opa [6], opb [6];
  logic signed [tbc_pkg::DOT_W+tbc_pkg::SPLIT:0] pl [6];
  logic signed [tbc_pkg::DOT_W+tbc_pkg::DOT_W-tbc_pkg::SPLIT-1:0] ph [6];

  always_comb begin
    opa = '{dot[0], dot[1], dot[2], dot[1], dot[0], dot[1]};
    opb = '{dot[2], dot[1], dot[3], dot[4], dot[4], dot[3]};
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 6; i++) begin
        pl[i] <= opa[i] * $signed({1'b0, opb[i][tbc_pkg::SPLIT-1:0]});
        ph[i] <= opa[i] * $signed(opb[i][tbc_pkg::DOT_W-1:tbc_pkg::SPLIT]);
      end
    end
  end

  // stage 5: recombine partial products
  logic signed [tbc_pkg::GPROD_W-1:0] gp [6];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 6; i++) begin
        gp[i] <= (tbc_pkg::GPROD_W'(ph[i]) <<< tbc_pkg::SPLIT) + tbc_pkg::GPROD_W'(pl[i]);
      end
    end
  end

  // stage 6: den, nv, nw
  logic signed [tbc_pkg::NUM_W-1:0] den, nv, nw;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      den <= tbc_pkg::NUM_W'(gp[0]) - tbc_pkg::NUM_W'(gp[1]);
      nv  <= tbc_pkg::NUM_W'(gp[2]) - tbc_pkg::NUM_W'(gp[3]);
      nw  <= tbc_pkg::NUM_W'(gp[4]) - tbc_pkg::NUM_W'(gp[5]);
    end
  end

  // stage 7: nu, magnitudes and quotient signs
  logic signed [tbc_pkg::NUM_W-1:0] nu;
  logic [tbc_pkg::NUM_W-1:0]        mag [3];
  logic [tbc_pkg::NUM_W-1:0]        dmag;
  logic [2:0]                       sgn;
  logic                             degen7;

  assign nu = den - nv - nw;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      mag[0] <= nu[tbc_pkg::NUM_W-1] ? -nu : nu;
      mag[1] <= nv[tbc_pkg::NUM_W-1] ? -nv : nv;
      mag[2] <= nw[tbc_pkg::NUM_W-1] ? -nw : nw;
      dmag   <= den[tbc_pkg::NUM_W-1] ? -den : den;
      sgn    <= {nw[tbc_pkg::NUM_W-1], nv[tbc_pkg::NUM_W-1], nu[tbc_pkg::NUM_W-1]}
                ^ {3{den[tbc_pkg::NUM_W-1]}};
      degen7 <= (den == '0);
    end
  end

  // stage 8: n = |num| * 2^(F+1) + |den|, divisor 2|den| aligned to the top quotient bit
  logic [tbc_pkg::R_W-1:0] n8 [3];
  logic [tbc_pkg::R_W-1:0] dsh8;

  always_comb begin
    dsh8 = tbc_pkg::R_W'(dmag) << tbc_pkg::WEIGHT_W;
    for (int i = 0; i < 3; i++) begin
      n8[i] = (tbc_pkg::R_W'(mag[i]) << (tbc_pkg::FRAC_BITS + 1)) + tbc_pkg::R_W'(dmag);
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      word.degen <= degen7;
      for (int i = 0; i < 3; i++) begin
        word.lane[i].rem <= n8[i];
        word.lane[i].dsh <= dsh8;
        word.lane[i].q   <= '0;
        word.lane[i].neg <= sgn[i];
        word.lane[i].big <= ({1'b0, n8[i]} >= {dsh8, 1'b0}) || degen7;
      end
    end
  end

  a_degen_zero_div: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> (word.degen == (word.lane[0].dsh == '0)))
    else $error("degenerate flag disagrees with divisor");

endmodule

FILE: hw/rtl/tbc_div_cell.sv
// One restoring-division cell: produces one quotient bit for each of the three
// weights and hands the word on. Depends on tbc_pkg.
module tbc_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  tbc_pkg::div_word_t  up_word,
  input  logic                up_valid,
  output logic                up_ready,
  output tbc_pkg::div_word_t  dn_word,
  output logic                dn_valid,
  input  logic                dn_ready
);

  logic en;

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_word.degen <= up_word.degen;
      for (int i = 0; i < tbc_pkg::N_LANES; i++) begin
        dn_word.lane[i].neg <= up_word.lane[i].neg;
        dn_word.lane[i].big <= up_word.lane[i].big;
        dn_word.lane[i].dsh <= up_word.lane[i].dsh >> 1;
        if (up_word.lane[i].rem >= up_word.lane[i].dsh) begin
          dn_word.lane[i].rem <= up_word.lane[i].rem - up_word.lane[i].dsh;
          dn_word.lane[i].q   <= {up_word.lane[i].q[tbc_pkg::WEIGHT_W-2:0], 1'b1};
        end else begin
          dn_word.lane[i].rem <= up_word.lane[i].rem;
          dn_word.lane[i].q   <= {up_word.lane[i].q[tbc_pkg::WEIGHT_W-2:0], 1'b0};
        end
      end
    end
  end

  // lane 1 remainder stays below four times the passed-on divisor when the quotient fits
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_word.lane[1].big |->
      ({2'b0, dn_word.lane[1].rem} < {dn_word.lane[1].dsh, 2'b0}))
    else $error("divider remainder out of bound");

endmodule

FILE: hw/rtl/triangle_barycentric_coords_top.sv
// Top level: barycentric weights of a query point for a 3D triangle.
// Depends on tbc_pkg, tbc_if, tbc_front, tbc_div_cell.
//
//  channel  dir  word
//  item     in   vertices A, B, C and query P, signed Q8.8
//  result   out  weights u, v, w (signed Q4.12, saturating), degenerate flag
//
// One word per cycle sustained while result is ready; a word passes 8 front stages,
// 16 divider cells and one output register. The 16-cell divider chain is the longest part.
// Synchronous reset clears all valid flags. Every stage collapses bubbles, so
// a stalled result only stops the stages behind it once they are all full.
module triangle_barycentric_coords_top (
  input  logic       clk,
  input  logic       rst,
  tbc_in_if.sink     item,
  tbc_out_if.source  result
);

  tbc_pkg::div_word_t cw [tbc_pkg::N_CELLS+1];
  logic [tbc_pkg::N_CELLS:0] cv;
  logic [tbc_pkg::N_CELLS:0] cr;

  tbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .word       (cw[0]),
    .word_valid (cv[0]),
    .word_ready (cr[0])
  );

  for (genvar g = 0; g < tbc_pkg::N_CELLS; g++) begin : g_cell
    tbc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_word  (cw[g]),
      .up_valid (cv[g]),
      .up_ready (cr[g]),
      .dn_word  (cw[g+1]),
      .dn_valid (cv[g+1]),
      .dn_ready (cr[g+1])
    );
  end

  logic en_o;
  logic [tbc_pkg::WEIGHT_W-1:0] wt [tbc_pkg::N_LANES];

  assign en_o                 = !result.valid || result.ready;
  assign cr[tbc_pkg::N_CELLS] = en_o;

  // round-to-nearest already folded into the dividend; zero degenerate words and saturate here
  always_comb begin
    for (int i = 0; i < tbc_pkg::N_LANES; i++) begin
      if (cw[tbc_pkg::N_CELLS].degen) begin
        wt[i] = '0;
      end else if (cw[tbc_pkg::N_CELLS].lane[i].neg) begin
        wt[i] = (cw[tbc_pkg::N_CELLS].lane[i].big
                 || cw[tbc_pkg::N_CELLS].lane[i].q > tbc_pkg::W_NEG_MAX)
                ? tbc_pkg::W_NEG_MAX : -cw[tbc_pkg::N_CELLS].lane[i].q;
      end else begin
        wt[i] = (cw[tbc_pkg::N_CELLS].lane[i].big
                 || cw[tbc_pkg::N_CELLS].lane[i].q[tbc_pkg::WEIGHT_W-1])
                ? tbc_pkg::W_POS_MAX : cw[tbc_pkg::N_CELLS].lane[i].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en_o) begin
      result.valid <= cv[tbc_pkg::N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      result.weight_u   <= wt[0];
      result.weight_v   <= wt[1];
      result.weight_w   <= wt[2];
      result.degenerate <= cw[tbc_pkg::N_CELLS].degen;
    end
  end

  a_degen_weights: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |->
      (result.weight_u == '0 && result.weight_v == '0 && result.weight_w == '0))
    else $error("degenerate word carries nonzero weights");

endmodule

FILE: verif/triangle_barycentric_coords_checker.sv
// Checker for the barycentric weight block: watches the query and weight channels,
// predicts each weight word with exact integer math and compares. Depends on tbc_if.
`timescale 1ns / 100ps

module triangle_barycentric_coords_checker (
  input  logic clk,
  input  logic rst,
  tbc_in_if    item,
  tbc_out_if   result,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] w;
    logic               degen;
  } weights_t;

  typedef logic signed [127:0] big_t;

  weights_t expected_weights[$];

  // round(num * 2^12 / den), ties away from zero, saturated to 16 bits
  function automatic logic signed [15:0] scaled_ratio(big_t num, big_t den);
    logic        neg;
    logic [127:0] n, d, q;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    q = ((n << 13) + d) / (d << 1);
    if (neg)
      return (q > 128'd32768) ? -16'sd32768 : -$signed(q[15:0]);
    return (q > 128'd32767) ? 16'sd32767 : $signed(q[15:0]);
  endfunction

  function automatic big_t dot(big_t x[3], big_t y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic weights_t barycentric(logic signed [15:0] a[3], logic signed [15:0] b[3],
                                           logic signed [15:0] c[3], logic signed [15:0] p[3]);
    big_t e1[3], e2[3], qo[3];
    big_t d11, d12, d22, d31, d32, den, nv, nw;
    weights_t r;
    for (int k = 0; k < 3; k++) begin
      e1[k] = big_t'(b[k]) - big_t'(a[k]);
      e2[k] = big_t'(c[k]) - big_t'(a[k]);
      qo[k] = big_t'(p[k]) - big_t'(a[k]);
    end
    d11 = dot(e1, e1);
    d12 = dot(e1, e2);
    d22 = dot(e2, e2);
    d31 = dot(qo, e1);
    d32 = dot(qo, e2);
    den = d11 * d22 - d12 * d12;
    r = '0;
    if (den == 0) begin
      r.degen = 1'b1;
    end else begin
      nv = d22 * d31 - d12 * d32;
      nw = d11 * d32 - d12 * d31;
      r.u = scaled_ratio(den - nv - nw, den);
      r.v = scaled_ratio(nv, den);
      r.w = scaled_ratio(nw, den);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic signed [15:0] a[3], b[3], c[3], p[3];
    weights_t exp_w;
    if (rst) begin
      expected_weights.delete();
      fail_count <= 0;
    end else begin
      if (item.valid && item.ready) begin
        a = '{item.vertex_a_x, item.vertex_a_y, item.vertex_a_z};
        b = '{item.vertex_b_x, item.vertex_b_y, item.vertex_b_z};
        c = '{item.vertex_c_x, item.vertex_c_y, item.vertex_c_z};
        p = '{item.query_x, item.query_y, item.query_z};
        expected_weights.push_back(barycentric(a, b, c, p));
      end
      if (result.valid && result.ready) begin
        if (expected_weights.size() == 0) begin
          $error("weight word with no query pending");
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_weights.pop_front();
          if (result.weight_u !== exp_w.u || result.weight_v !== exp_w.v ||
              result.weight_w !== exp_w.w || result.degenerate !== exp_w.degen) begin
            if (result.weight_u !== exp_w.u)
              $error("weight_u expected %0d got %0d", exp_w.u, result.weight_u);
            if (result.weight_v !== exp_w.v)
              $error("weight_v expected %0d got %0d", exp_w.v, result.weight_v);
            if (result.weight_w !== exp_w.w)
              $error("weight_w expected %0d got %0d", exp_w.w, result.weight_w);
            if (result.degenerate !== exp_w.degen)
              $error("degenerate expected %0d got %0d", exp_w.degen, result.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = expected_weights.size();

endmodule

FILE: verif/triangle_barycentric_coords_top_tb.sv
// Top of the barycentric weight testbench: clock, reset, query stimulus, result stalls
// and verdict. Depends on tbc_pkg, tbc_if, the block and triangle_barycentric_coords_checker.
`timescale 1ns / 100ps

module triangle_barycentric_coords_top_tb;

  localparam int N_RANDOM  = 1650;
  localparam int LIMIT     = 400000;
  localparam int DRAIN     = 40;

  typedef struct {
    int a[3];
    int b[3];
    int c[3];
    int p[3];
  } tri_query_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  bit   steady;   // no idling on either side while set

  tbc_in_if  item ();
  tbc_out_if result ();

  triangle_barycentric_coords_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  triangle_barycentric_coords_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles == LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int srange(int lo, int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (steady) begin
      result.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 4) begin
      result.ready <= 1'b0;  // start of a long stall, held below
    end else if (!result.ready && $urandom_range(0, 19) != 0 && $urandom_range(0, 1) == 0) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(0, 99) < 75);
    end
  end

  task automatic send_query(tri_query_t t);
    int g;
    g = gap_len();
    if (g > 0) begin
      item.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item.valid      <= 1'b1;
    item.vertex_a_x <= 16'(t.a[0]);
    item.vertex_a_y <= 16'(t.a[1]);
    item.vertex_a_z <= 16'(t.a[2]);
    item.vertex_b_x <= 16'(t.b[0]);
    item.vertex_b_y <= 16'(t.b[1]);
    item.vertex_b_z <= 16'(t.b[2]);
    item.vertex_c_x <= 16'(t.c[0]);
    item.vertex_c_y <= 16'(t.c[1]);
    item.vertex_c_z <= 16'(t.c[2]);
    item.query_x    <= 16'(t.p[0]);
    item.query_y    <= 16'(t.p[1]);
    item.query_z    <= 16'(t.p[2]);
    do @(posedge clk); while (!item.ready);
  endtask

  task automatic send_fixed(int ax, int ay, int az, int bx, int by, int bz,
                            int cx, int cy, int cz, int px, int py, int pz);
    tri_query_t t;
    t.a = '{ax, ay, az};
    t.b = '{bx, by, bz};
    t.c = '{cx, cy, cz};
    t.p = '{px, py, pz};
    send_query(t);
  endtask

  function automatic tri_query_t random_query();
    tri_query_t t;
    int kind, s, u;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      if (kind < 2) begin
        // raw words, every bit free
        t.a[k] = $signed(16'($urandom));
        t.b[k] = $signed(16'($urandom));
        t.c[k] = $signed(16'($urandom));
        t.p[k] = $signed(16'($urandom));
      end else begin
        t.a[k] = srange(-16000, 16000);
        t.b[k] = t.a[k] + srange(-256, 256);
        t.c[k] = t.a[k] + srange(-256, 256);
        t.p[k] = t.a[k] + srange(-400, 400);
      end
    end
    if (kind == 2) begin
      // collinear or coincident vertices
      s = srange(-2, 2);
      for (int k = 0; k < 3; k++) t.c[k] = t.a[k] + s * (t.b[k] - t.a[k]);
    end else if (kind >= 6) begin
      // query near the triangle plane
      s = srange(-2, 6);
      u = srange(-2, 6);
      for (int k = 0; k < 3; k++)
        t.p[k] = t.a[k] + (s * (t.b[k] - t.a[k]) + u * (t.c[k] - t.a[k])) / 4
                 + srange(-1, 1);
    end
    return t;
  endfunction

  initial begin
    steady       = 1'b0;
    rst          = 1'b1;
    item.valid   = 1'b0;
    item.vertex_a_x = '0; item.vertex_a_y = '0; item.vertex_a_z = '0;
    item.vertex_b_x = '0; item.vertex_b_y = '0; item.vertex_b_z = '0;
    item.vertex_c_x = '0; item.vertex_c_y = '0; item.vertex_c_z = '0;
    item.query_x = '0; item.query_y = '0; item.query_z = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all zero: degenerate
    send_fixed(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // unit triangle, query on each vertex and inside
    send_fixed(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0);
    send_fixed(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0);
    send_fixed(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 256, 0);
    send_fixed(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0);
    // off-plane query projects onto the triangle
    send_fixed(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 5000);
    // half-step ties, both signs
    send_fixed(0, 0, 0, 8192, 0, 0, 0, 8192, 0, 1, 0, 0);
    send_fixed(0, 0, 0, 8192, 0, 0, 0, 8192, 0, -1, 0, 0);
    send_fixed(0, 0, 0, 8192, 0, 0, 0, 8192, 0, 0, -3, 0);
    // saturation from a far query on a tiny triangle
    send_fixed(0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 0, 0);
    send_fixed(0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, -32768, 0);
    send_fixed(0, 0, 0, 1, 0, 0, 0, 1, 0, 8, 8, 0);
    // extreme coordinates
    send_fixed(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767,
               32767, 32767, 32767);
    send_fixed(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, -32768,
               -32768, -32768, -32768);
    send_fixed(-32768, 32767, -32768, 32767, -32768, 32767, 0, 0, 0, -1, -1, -1);
    // collinear and coincident vertices
    send_fixed(0, 0, 0, 100, 100, 100, 200, 200, 200, 5, 6, 7);
    send_fixed(1000, -1000, 5, 1000, -1000, 5, 1000, -1000, 5, 0, 0, 0);
    send_fixed(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 1, 2, 3);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 0) steady = ($urandom_range(0, 3) == 0);
      send_query(random_query());
    end
    item.valid <= 1'b0;
    steady = 1'b0;

    // let the checker log the last word before watching the backlog
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
